@@ hw/rtl/pba_pkg.sv @@
// shared types and constants for the page bitmap allocator
package pba_pkg;

   localparam int DEFAULT_MAX_PAGES = 131072;

   localparam int FIRST_PAGE_W  = 17;
   localparam int RUN_LEN_W     = 18;
   localparam int TOTAL_PAGES_W = 18;
   localparam int START_PAGE_W  = 17;
   localparam int LOCKED_W      = 18;

   // bitmap word geometry
   localparam int BITS_PER_WORD = 8;
   localparam int BIT_W         = 3;
   localparam int DELTA_W       = 4;

   // free run length during a search stays below the requested length
   localparam int RUN_W = RUN_LEN_W + 1;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_REG_TOTAL_PAGES = 1'b0;

   typedef enum logic [1:0] {
      CMD_LOCK   = 2'd0,
      CMD_UNLOCK = 2'd1,
      CMD_ALLOC  = 2'd2,
      CMD_COUNT  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [FIRST_PAGE_W-1:0] first_page;
      logic [RUN_LEN_W-1:0]    run_length;
   } req_type;

   typedef struct packed {
      logic [START_PAGE_W-1:0] start_page;
      logic                    found;
      logic [LOCKED_W-1:0]     locked_total;
   } rsp_type;

   typedef struct packed {
      logic             match;
      logic [BIT_W-1:0] match_bit;
      logic [RUN_W-1:0] run_next;
   } scan_result_type;

   typedef struct packed {
      logic [BIT_W-1:0] lo_bit;
      logic [BIT_W-1:0] hi_bit;
   } word_span_type;

   typedef struct packed {
      logic [BITS_PER_WORD-1:0] word;
      logic [DELTA_W-1:0]       delta;
   } update_result_type;

endpackage

@@ hw/rtl/pba_bitmap_mem.sv @@
// bitmap storage: one write port, one read port with registered read data
module pba_bitmap_mem
   import pba_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_PAGES / BITS_PER_WORD,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [BITS_PER_WORD-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [BITS_PER_WORD-1:0] rd_data
);

   logic [BITS_PER_WORD-1:0] bitmap_ff [DEPTH];
   logic [BITS_PER_WORD-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= bitmap_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/pba_word_scan.sv @@
// first-fit scan of one bitmap word, carrying the free run from earlier words
module pba_word_scan
   import pba_pkg::*;
(
   input  logic [BITS_PER_WORD-1:0] word,
   input  logic [BIT_W-1:0]         hi_bit,
   input  logic [RUN_W-1:0]         run_in,
   input  logic [RUN_LEN_W-1:0]     run_length,
   output scan_result_type          result
);

   logic [BITS_PER_WORD-1:0] free;
   logic [DELTA_W-1:0]       local_run [BITS_PER_WORD];
   logic [RUN_W-1:0]         total     [BITS_PER_WORD];

   // bits above hi_bit lie past the page limit and count as used
   always_comb begin
      for (int i = 0; i < BITS_PER_WORD; i++) begin
         free[i] = !word[i] && (BIT_W'(i) <= hi_bit);
      end
   end

   // free run ending at each bit, counted inside the word
   always_comb begin
      local_run[0] = free[0] ? DELTA_W'(1) : '0;
      for (int i = 1; i < BITS_PER_WORD; i++) begin
         local_run[i] = free[i] ? local_run[i-1] + DELTA_W'(1) : '0;
      end
   end

   always_comb begin
      for (int i = 0; i < BITS_PER_WORD; i++) begin
         if (local_run[i] == DELTA_W'(i + 1)) begin
            total[i] = run_in + RUN_W'(i + 1);
         end else begin
            total[i] = RUN_W'(local_run[i]);
         end
      end
   end

   // lowest bit at which the run reaches the requested length wins
   always_comb begin
      result.match     = 1'b0;
      result.match_bit = '0;
      for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
         if (free[i] && (total[i] >= RUN_W'(run_length))) begin
            result.match     = 1'b1;
            result.match_bit = BIT_W'(i);
         end
      end
      if (local_run[BITS_PER_WORD-1] == DELTA_W'(BITS_PER_WORD)) begin
         result.run_next = run_in + RUN_W'(BITS_PER_WORD);
      end else begin
         result.run_next = RUN_W'(local_run[BITS_PER_WORD-1]);
      end
   end

endmodule

@@ hw/rtl/pba_word_update.sv @@
// sets or clears a span of bits in one bitmap word and counts the changed bits
module pba_word_update
   import pba_pkg::*;
(
   input  logic [BITS_PER_WORD-1:0] word,
   input  word_span_type            span,
   input  logic                     set,
   output update_result_type        result
);

   logic [BITS_PER_WORD-1:0] mask;
   logic [BITS_PER_WORD-1:0] changed;

   always_comb begin
      for (int i = 0; i < BITS_PER_WORD; i++) begin
         mask[i] = (BIT_W'(i) >= span.lo_bit) && (BIT_W'(i) <= span.hi_bit);
      end
   end

   always_comb begin
      if (set) begin
         changed     = mask & ~word;
         result.word = word | mask;
      end else begin
         changed     = mask & word;
         result.word = word & ~mask;
      end
      result.delta = DELTA_W'($countones(changed));
   end

endmodule

@@ hw/rtl/page_bitmap_allocator.sv @@
// First-fit page allocator over an in-use bitmap of MAX_PAGES pages, kept in a
// memory of 8-bit words with one read and one write port. After reset a
// clearing pass writes every word before the first transaction is taken;
// configuration writes are taken during it. Lock and unlock read and rewrite
// each bitmap word that the clipped range touches. Alloc scans words up to the
// word holding the last page of the run found, then makes a locking pass over
// the words of the run; when no run fits it scans every word of the managed
// space, and a zero-length or oversized alloc scans none. The single read port
// streams one word per cycle through the read-modify-write path. One transaction
// is worked on at a time; a finished result waits in the output register while
// the next transaction is taken. The locked-page total is a running count.
module page_bitmap_allocator
   import pba_pkg::*;
#(
   parameter int MAX_PAGES = DEFAULT_MAX_PAGES
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int WORDS = (MAX_PAGES + BITS_PER_WORD - 1) / BITS_PER_WORD;
   localparam int AW    = $clog2(WORDS);
   localparam int PW    = AW + BIT_W;
   localparam int PCW   = $clog2(MAX_PAGES + 1);
   localparam int XW    = (PCW > RUN_W) ? PCW : RUN_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_RANGE,
      ST_SEARCH,
      ST_PLACE,
      ST_MARK,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [XW-1:0]            total_ff, total_in;
   logic [PCW-1:0]           lim_ff, lim_in;
   logic [PW-1:0]            lim_last_ff, lim_last_in;
   logic [XW-1:0]            end_ff, end_in;
   logic [PW-1:0]            lo_ff, lo_in;
   logic [PW-1:0]            hi_last_ff, hi_last_in;
   logic [AW-1:0]            last_word_ff, last_word_in;
   logic [AW-1:0]            rd_addr_ff, rd_addr_in;
   logic                     issue_done_ff, issue_done_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pend_word_ff, pend_word_in;
   logic [RUN_W-1:0]         run_ff, run_in;
   logic [PW-1:0]            match_page_ff, match_page_in;
   logic [PW-1:0]            start_ff, start_in;
   logic                     found_ff, found_in;
   logic [PCW-1:0]           count_ff, count_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     issue_now;
   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr;
   logic [BITS_PER_WORD-1:0] mem_wr_data;
   logic [BITS_PER_WORD-1:0] mem_rd_data;
   logic                     csr_write;

   logic [BIT_W-1:0]         scan_hi_bit;
   scan_result_type          scan_result;
   word_span_type            mark_span;
   logic                     mark_set;
   update_result_type        update_result;

   logic [XW-1:0]            end_raw;
   logic [PW-1:0]            range_hi_last;
   logic [PW-1:0]            place_lo;
   logic [XW-1:0]            start_wide;
   logic [XW-1:0]            count_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign pready = 1'b1;

   assign csr_write = psel && penable && pwrite &&
                      (paddr[CSR_ADDR_W-1] == CSR_REG_TOTAL_PAGES);

   always_comb begin
      if (paddr[CSR_ADDR_W-1] == CSR_REG_TOTAL_PAGES) begin
         prdata = CSR_DATA_W'(total_ff);
      end else begin
         prdata = '0;
      end
   end

   assign issue_now = ((state_ff == ST_SEARCH) || (state_ff == ST_MARK)) && !issue_done_ff;

   pba_bitmap_mem #(
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (issue_now),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rd_data)
   );

   assign scan_hi_bit = (pend_word_ff == last_word_ff) ? lim_last_ff[BIT_W-1:0]
                                                       : BIT_W'(BITS_PER_WORD - 1);

   pba_word_scan u_scan (
      .word       (mem_rd_data),
      .hi_bit     (scan_hi_bit),
      .run_in     (run_ff),
      .run_length (req_ff.run_length),
      .result     (scan_result)
   );

   always_comb begin
      mark_span.lo_bit = (pend_word_ff == lo_ff[PW-1:BIT_W]) ? lo_ff[BIT_W-1:0] : '0;
      mark_span.hi_bit = (pend_word_ff == last_word_ff) ? hi_last_ff[BIT_W-1:0]
                                                        : BIT_W'(BITS_PER_WORD - 1);
   end

   assign mark_set = (req_ff.cmd != CMD_UNLOCK);

   pba_word_update u_update (
      .word   (mem_rd_data),
      .span   (mark_span),
      .set    (mark_set),
      .result (update_result)
   );

   // clearing pass owns the write port until it is done
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = (state_ff == ST_MARK) && pend_ff;
         mem_wr_addr = pend_word_ff;
         mem_wr_data = update_result.word;
      end
   end

   assign end_raw       = XW'(req_ff.first_page) + XW'(req_ff.run_length);
   assign range_hi_last = PW'(end_ff - XW'(1));
   assign place_lo      = PW'(XW'(match_page_ff) - XW'(req_ff.run_length) + XW'(1));
   assign start_wide    = XW'(start_ff);
   assign count_wide    = XW'(count_ff);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      total_in      = total_ff;
      lim_in        = (total_ff < XW'(MAX_PAGES)) ? PCW'(total_ff) : PCW'(MAX_PAGES);
      lim_last_in   = lim_last_ff;
      end_in        = end_ff;
      lo_in         = lo_ff;
      hi_last_in    = hi_last_ff;
      last_word_in  = last_word_ff;
      rd_addr_in    = rd_addr_ff;
      issue_done_in = issue_done_ff;
      pend_in       = issue_now;
      pend_word_in  = rd_addr_ff;
      run_in        = run_ff;
      match_page_in = match_page_ff;
      start_in      = start_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      clr_addr_in   = clr_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_write) begin
         total_in = XW'(pwdata[TOTAL_PAGES_W-1:0]);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (issue_now) begin
         rd_addr_in = rd_addr_ff + AW'(1);
         if (rd_addr_ff == last_word_ff) begin
            issue_done_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            start_in = '0;
            found_in = 1'b0;
            end_in   = (end_raw > XW'(lim_ff)) ? XW'(lim_ff) : end_raw;
            lim_last_in = PW'(XW'(lim_ff) - XW'(1));
            unique case (req_ff.cmd) inside
               CMD_LOCK, CMD_UNLOCK: begin
                  state_in = ST_RANGE;
               end
               CMD_ALLOC: begin
                  if ((req_ff.run_length != '0) &&
                      (XW'(req_ff.run_length) <= XW'(lim_ff))) begin
                     rd_addr_in    = '0;
                     last_word_in  = lim_last_in[PW-1:BIT_W];
                     issue_done_in = 1'b0;
                     run_in        = '0;
                     state_in      = ST_SEARCH;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_RANGE: begin
            // range clipped to the limit may be empty
            if (XW'(req_ff.first_page) < end_ff) begin
               lo_in         = PW'(req_ff.first_page);
               hi_last_in    = range_hi_last;
               rd_addr_in    = lo_in[PW-1:BIT_W];
               last_word_in  = range_hi_last[PW-1:BIT_W];
               issue_done_in = 1'b0;
               state_in      = ST_MARK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (pend_ff) begin
               if (scan_result.match) begin
                  match_page_in = {pend_word_ff, scan_result.match_bit};
                  state_in      = ST_PLACE;
               end else begin
                  run_in = scan_result.run_next;
                  if (pend_word_ff == last_word_ff) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_PLACE: begin
            lo_in         = place_lo;
            hi_last_in    = match_page_ff;
            start_in      = place_lo;
            found_in      = 1'b1;
            rd_addr_in    = place_lo[PW-1:BIT_W];
            last_word_in  = match_page_ff[PW-1:BIT_W];
            issue_done_in = 1'b0;
            state_in      = ST_MARK;
         end
         ST_MARK: begin
            if (pend_ff) begin
               if (mark_set) begin
                  count_in = count_ff + PCW'(update_result.delta);
               end else begin
                  count_in = count_ff - PCW'(update_result.delta);
               end
               if (pend_word_ff == last_word_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.start_page   = start_wide[START_PAGE_W-1:0];
               rsp_data_in.found        = found_ff;
               rsp_data_in.locked_total = count_wide[LOCKED_W-1:0];
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         total_ff      <= XW'(MAX_PAGES);
         lim_ff        <= PCW'(MAX_PAGES);
         issue_done_ff <= 1'b1;
         pend_ff       <= 1'b0;
         count_ff      <= '0;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         lim_ff        <= lim_in;
         issue_done_ff <= issue_done_in;
         pend_ff       <= pend_in;
         count_ff      <= count_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff        <= req_in;
      lim_last_ff   <= lim_last_in;
      end_ff        <= end_in;
      lo_ff         <= lo_in;
      hi_last_ff    <= hi_last_in;
      last_word_ff  <= last_word_in;
      rd_addr_ff    <= rd_addr_in;
      pend_word_ff  <= pend_word_in;
      run_ff        <= run_in;
      match_page_ff <= match_page_in;
      start_ff      <= start_in;
      found_ff      <= found_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
